// File: sv/tsq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsq_pkg
// Shared types and constants for the timed squelch table unit.
// ----------------------------------------------------------------------------
package tsq_pkg;

  // Table geometry.
  localparam int ENTRIES  = 64;
  localparam int KEY_BITS = 64;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W    = $clog2(ENTRIES + 1);

  // Fixed field widths.
  localparam int DUR_W  = 16;
  localparam int TIME_W = 32;

  // Register reset values.
  localparam logic [DUR_W-1:0] MIN_DUR_RESET = 16'd300;
  localparam logic [DUR_W-1:0] MAX_DUR_RESET = 16'd3600;

  // Register indexes on the configuration port.
  localparam logic REG_MIN_DURATION = 1'b0;
  localparam logic REG_MAX_DURATION = 1'b1;

  // Operation codes.
  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_CHECK  = 2'd2
  } func_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             commit;
  } cmd_t;

endpackage

// File: sv/tsq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsq_ctrl
// Sequencer: accepts a transaction, sweeps the table one entry per cycle,
// commits the update and hands the response to the output register.
// ----------------------------------------------------------------------------
module tsq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output tsq_pkg::cmd_t cmd
);

  tsq_pkg::state_t              state, state_next;
  logic [tsq_pkg::CNT_W-1:0]    cnt, cnt_next;
  logic                         out_valid, out_valid_next;

  // State, sweep counter and output-valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tsq_pkg::ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cmd            = '0;
    cmd.rd_addr    = cnt[tsq_pkg::IDX_W-1:0];
    s_tready       = 1'b0;
    out_valid_next = out_valid && !m_tready;
    case (state)
      tsq_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = tsq_pkg::ST_SCAN;
        end
      end
      tsq_pkg::ST_SCAN: begin
        // One read is issued per entry; a final sweep step without a read lets the last compare land.
        cmd.rd_en = (cnt < tsq_pkg::CNT_W'(tsq_pkg::ENTRIES));
        cnt_next  = cnt + 1'b1;
        if (cnt == tsq_pkg::CNT_W'(tsq_pkg::ENTRIES)) begin
          state_next = tsq_pkg::ST_WRITE;
        end
      end
      tsq_pkg::ST_WRITE: begin
        // Commit only once the output register is free or being drained.
        if (!out_valid || m_tready) begin
          cmd.commit     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = tsq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tsq_pkg::ST_IDLE;
      end
    endcase
  end

  assign m_tvalid = out_valid;

endmodule

// File: sv/tsq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsq_dp
// Datapath: item registers, key and expiry memory, valid bits, match and
// free-slot search, update decision and response register.
// ----------------------------------------------------------------------------
module tsq_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  tsq_pkg::cmd_t              cmd,
  input  logic [1:0]                 in_func,
  input  logic [63:0]                in_source_id,
  input  logic [tsq_pkg::DUR_W-1:0]  in_duration,
  input  logic [tsq_pkg::TIME_W-1:0] in_now,
  input  logic [tsq_pkg::DUR_W-1:0]  min_duration,
  input  logic [tsq_pkg::DUR_W-1:0]  max_duration,
  output logic                       ok,
  output logic                       full_res
);

  localparam int MEM_W = tsq_pkg::KEY_BITS + tsq_pkg::TIME_W;

  // Item registers.
  logic [1:0]                   func;
  logic [tsq_pkg::KEY_BITS-1:0] key;
  logic [tsq_pkg::DUR_W-1:0]    dur;
  logic [tsq_pkg::TIME_W-1:0]   now;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func <= in_func;
      key  <= in_source_id[tsq_pkg::KEY_BITS-1:0];
      dur  <= in_duration;
      now  <= in_now;
    end
  end

  // Key and expiry memory with a registered read port.
  logic [MEM_W-1:0]             mem [tsq_pkg::ENTRIES];
  logic [MEM_W-1:0]             rd_data;
  logic [tsq_pkg::ENTRIES-1:0]  valid;
  logic                         rd_valid;
  logic                         cmp_en;
  logic [tsq_pkg::IDX_W-1:0]    cmp_idx;
  logic                         mem_we;
  logic [tsq_pkg::IDX_W-1:0]    widx;
  logic [tsq_pkg::TIME_W-1:0]   new_exp;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[widx] <= {key, new_exp};
    end
    if (cmd.rd_en) begin
      rd_data  <= mem[cmd.rd_addr];
      rd_valid <= valid[cmd.rd_addr];
    end
    cmp_idx <= cmd.rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_en <= 1'b0;
    end else begin
      cmp_en <= cmd.rd_en;
    end
  end

  // Search: remember the matching entry and the lowest free entry.
  logic                       found, free_hit;
  logic [tsq_pkg::IDX_W-1:0]  match_idx, free_idx;
  logic [tsq_pkg::TIME_W-1:0] match_exp;
  logic                       hit;

  assign hit = cmp_en && rd_valid &&
               (rd_data[MEM_W-1:tsq_pkg::TIME_W] == key);

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      found    <= 1'b0;
      free_hit <= 1'b0;
    end else begin
      if (hit) begin
        found <= 1'b1;
      end
      if (cmp_en && !rd_valid && !free_hit) begin
        free_hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      match_idx <= cmp_idx;
      match_exp <= rd_data[tsq_pkg::TIME_W-1:0];
    end
    if (cmp_en && !rd_valid && !free_hit) begin
      free_idx <= cmp_idx;
    end
  end

  // Saturating expiry time.
  logic [tsq_pkg::TIME_W:0] exp_sum;
  logic                     dur_ok;

  assign exp_sum = {1'b0, now} + (tsq_pkg::TIME_W + 1)'(dur);
  assign new_exp = exp_sum[tsq_pkg::TIME_W] ? '1 : exp_sum[tsq_pkg::TIME_W-1:0];
  assign dur_ok  = (dur >= min_duration) && (dur <= max_duration);

  // Update decision.
  logic clr_en;
  logic ok_next, full_next;

  always_comb begin
    mem_we    = 1'b0;
    clr_en    = 1'b0;
    widx      = match_idx;
    ok_next   = 1'b0;
    full_next = 1'b0;
    case (func)
      tsq_pkg::FUNC_ADD: begin
        if (dur_ok) begin
          if (found) begin
            mem_we  = cmd.commit;
            ok_next = 1'b1;
          end else if (free_hit) begin
            widx    = free_idx;
            mem_we  = cmd.commit;
            ok_next = 1'b1;
          end else begin
            full_next = 1'b1;
          end
        end else begin
          clr_en = cmd.commit && found;
        end
      end
      tsq_pkg::FUNC_REMOVE: begin
        clr_en  = cmd.commit && found;
        ok_next = 1'b1;
      end
      tsq_pkg::FUNC_CHECK: begin
        // A live entry is still squelched; an expired one is dropped.
        if (!found) begin
          ok_next = 1'b1;
        end else if (match_exp <= now) begin
          clr_en  = cmd.commit;
          ok_next = 1'b1;
        end
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (mem_we) begin
      valid[widx] <= 1'b1;
    end else if (clr_en) begin
      valid[widx] <= 1'b0;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ok       <= ok_next;
      full_res <= full_next;
    end
  end

endmodule

// File: sv/timed_squelch_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_squelch_table_unit
// Keyed table of squelched sources with expiry times.
// ----------------------------------------------------------------------------
// Each transaction (add, remove or check) goes from acceptance to result in
// steps: an accept step, a sweep that reads the key/expiry memory one entry
// per cycle plus a final step for the last compare, and a commit step that
// waits for a free or draining output register. A new transaction is taken
// while the previous result still waits in the output register. The table
// starts empty after reset with no clearing pass. Operation code goes in
// s_tuser; duration bounds are set over the APB port at 0x0 and 0x4.
// ----------------------------------------------------------------------------
module timed_squelch_table_unit (
  input  logic          clk,
  input  logic          rst,
  // Input stream.
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [111:0]  s_tdata,   // source_id[63:0], duration[79:64], now[111:80]
  input  logic [1:0]    s_tuser,   // func[1:0]
  // Result stream.
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [7:0]    m_tdata,   // ok[0], full_res[1], zero[7:2]
  // Configuration port.
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  // Configuration registers.
  logic [tsq_pkg::DUR_W-1:0] min_duration;
  logic [tsq_pkg::DUR_W-1:0] max_duration;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_duration <= tsq_pkg::MIN_DUR_RESET;
      max_duration <= tsq_pkg::MAX_DUR_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == tsq_pkg::REG_MIN_DURATION) begin
        min_duration <= pwdata[tsq_pkg::DUR_W-1:0];
      end else begin
        max_duration <= pwdata[tsq_pkg::DUR_W-1:0];
      end
    end
  end

  // Register read-back.
  always_comb begin
    if (paddr[2] == tsq_pkg::REG_MAX_DURATION) begin
      prdata = {16'd0, max_duration};
    end else begin
      prdata = {16'd0, min_duration};
    end
  end

  tsq_pkg::cmd_t cmd;
  logic          ok;
  logic          full_res;

  tsq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  tsq_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .in_func      (s_tuser),
    .in_source_id (s_tdata[63:0]),
    .in_duration  (s_tdata[79:64]),
    .in_now       (s_tdata[111:80]),
    .min_duration (min_duration),
    .max_duration (max_duration),
    .ok           (ok),
    .full_res     (full_res)
  );

  assign m_tdata = {6'd0, full_res, ok};

endmodule
